>>> src/rti_pkg.sv
// Shared types, widths and codes of the ray/triangle intersection block.
// No dependencies; every other file imports it.
`default_nettype none
package rti_pkg;

   localparam int CW   = 32;          // coordinate width, signed Q(CW-FB).FB
   localparam int FB   = 16;          // fraction bits
   localparam int EW   = CW + 1;      // edge and negated-direction width
   localparam int XW   = 2 * EW + 1;  // cross product component width
   localparam int LOW  = EW;          // low half of a cross component
   localparam int MW   = EW + 1;      // multiplier operand width
   localparam int HW   = XW - LOW;    // high half of a cross component
   localparam int PW   = 2 * MW;      // product width
   localparam int DW   = PW + LOW + 2; // determinant accumulator width
   localparam int NW   = DW + FB;     // scaled dividend width
   localparam int QW   = CW + 1;      // quotient magnitude width
   localparam int CNTW = $clog2(QW);

   localparam logic [2:0] REQ_ORIGIN = 3'd0;
   localparam logic [2:0] REQ_DIR    = 3'd1;
   localparam logic [2:0] REQ_V0     = 3'd2;
   localparam logic [2:0] REQ_V1     = 3'd3;
   localparam logic [2:0] REQ_TEST   = 3'd4;

   localparam logic [1:0] KIND_CROSS = 2'd0;
   localparam logic [1:0] KIND_DOT   = 2'd1;
   localparam logic [1:0] KIND_DIR   = 2'd2;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic [2:0] req_type;
      coord_type  coord_x;
      coord_type  coord_y;
      coord_type  coord_z;
   } rti_req_type;

   typedef struct packed {
      logic      hit;
      coord_type distance;
      coord_type hit_x;
      coord_type hit_y;
      coord_type hit_z;
   } rti_rsp_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       mul_en;
      logic [1:0] kind;
      logic [1:0] idx;
      logic [1:0] comp;
      logic       half;
      logic       div_init;
      logic       div_step;
      logic       dist_wr;
      logic       out_load;
      logic       out_hit;
   } rti_cmd_type;

   typedef struct packed {
      logic miss;
   } rti_sts_type;

endpackage
`default_nettype wire

>>> src/rti_datapath.sv
// Datapath: vector store, shared multiplier with accumulator, divider, output register.
// Depends on rti_pkg; driven by rti_controller commands.
`default_nettype none
module rti_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  rti_pkg::rti_req_type req_data,
   input  rti_pkg::rti_cmd_type cmd,
   output rti_pkg::rti_sts_type sts,
   output rti_pkg::rti_rsp_type rsp_data
);
   import rti_pkg::*;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [1:0] idx;
      logic [1:0] comp;
      logic       half;
   } mul_ctrl_type;

   coord_type org_ff [3];
   coord_type dir_ff [3];
   coord_type v0_ff  [3];
   coord_type v1_ff  [3];
   coord_type coord  [3];

   logic signed [EW-1:0] vec_ff [4][3];
   logic signed [XW-1:0] xp_ff  [3][3];
   logic signed [DW-1:0] det_ff [4];
   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff;
   mul_ctrl_type         ctrl_ff, ctrl_in;

   logic signed [MW-1:0] opa, opb;
   logic [1:0]           u, v, k1, k2, av, xi;
   logic signed [XW-1:0] xsel;
   logic signed [EW-1:0] ea, eb;

   logic signed [DW-1:0] ext, term, base;
   logic                 first, neg, last_x, last_d;

   logic signed [DW:0]   sum_uv, den_x;
   logic [DW-1:0]        ntm, den_u;
   logic [NW-1:0]        numm;
   logic [DW-1:0]        rem_ff;
   logic [DW:0]          trial, diff;
   logic                 ge;
   logic [QW-1:0]        low_ff, quot_ff;
   logic                 negq_ff, ovf_ff;
   coord_type            dist_ff, dist_n;
   logic [CW:0]          mag_ff, mag_n;
   logic [QW-1:0]        lim_hi, lim_lo, qneg;

   logic signed [PW-1:0] adj, shr, cmax_p, cmin_p;
   coord_type            hv;
   coord_type            hit_ff [3];
   rti_rsp_type          rsp_ff;

   localparam coord_type CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CW-1){1'b0}}};

   assign coord[0] = req_data.coord_x;
   assign coord[1] = req_data.coord_y;
   assign coord[2] = req_data.coord_z;

   // operand select
   always_comb begin
      k1   = (cmd.comp == 2'd2) ? 2'd0 : cmd.comp + 2'd1;
      k2   = (cmd.comp == 2'd0) ? 2'd2 : cmd.comp - 2'd1;
      case (cmd.idx)
         2'd0:    begin u = 2'd1; v = 2'd3; end
         2'd1:    begin u = 2'd2; v = 2'd3; end
         default: begin u = 2'd1; v = 2'd2; end
      endcase
      av   = (cmd.idx == 2'd1) ? 2'd2 : 2'd0;
      case (cmd.idx)
         2'd0, 2'd1: xi = 2'd0;
         2'd2:       xi = 2'd1;
         default:    xi = 2'd2;
      endcase
      xsel = xp_ff[xi][cmd.comp];
      ea   = '0;
      eb   = '0;
      opa  = '0;
      opb  = '0;
      case (cmd.kind)
         KIND_CROSS: begin
            ea  = cmd.half ? vec_ff[u][k2] : vec_ff[u][k1];
            eb  = cmd.half ? vec_ff[v][k1] : vec_ff[v][k2];
            opa = {{(MW-EW){ea[EW-1]}}, ea};
            opb = {{(MW-EW){eb[EW-1]}}, eb};
         end
         KIND_DOT: begin
            ea  = vec_ff[av][cmd.comp];
            opa = {{(MW-EW){ea[EW-1]}}, ea};
            opb = cmd.half ? MW'(signed'(xsel[XW-1:LOW]))
                           : signed'({{(MW-LOW){1'b0}}, xsel[LOW-1:0]});
         end
         KIND_DIR: begin
            opa = {{(MW-CW){dir_ff[cmd.comp][CW-1]}}, dir_ff[cmd.comp]};
            opb = signed'({{(MW-CW-1){1'b0}}, mag_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      ctrl_in.valid = cmd.mul_en;
      ctrl_in.kind  = cmd.kind;
      ctrl_in.idx   = cmd.idx;
      ctrl_in.comp  = cmd.comp;
      ctrl_in.half  = cmd.half;
   end

   // accumulate stage
   always_comb begin
      ext    = {{(DW-PW){prod_ff[PW-1]}}, prod_ff};
      term   = (ctrl_ff.kind == KIND_DOT && ctrl_ff.half) ? (ext <<< LOW) : ext;
      first  = (ctrl_ff.kind == KIND_CROSS) ? !ctrl_ff.half
                                            : (ctrl_ff.comp == 2'd0 && !ctrl_ff.half);
      neg    = (ctrl_ff.kind == KIND_CROSS) && ctrl_ff.half;
      last_x = ctrl_ff.valid && (ctrl_ff.kind == KIND_CROSS) && ctrl_ff.half;
      last_d = ctrl_ff.valid && (ctrl_ff.kind == KIND_DOT) && ctrl_ff.half
               && (ctrl_ff.comp == 2'd2);
      base   = first ? '0 : acc_ff;
      acc_in = neg ? base - term : base + term;
   end

   // acceptance tests
   always_comb begin
      sum_uv   = {det_ff[1][DW-1], det_ff[1]} + {det_ff[2][DW-1], det_ff[2]};
      den_x    = {det_ff[0][DW-1], det_ff[0]};
      sts.miss = (det_ff[0] <= 0) || (det_ff[1] < 0) || (det_ff[1] > det_ff[0])
                 || (det_ff[2] < 0) || (det_ff[2] > det_ff[0]) || (sum_uv > den_x);
   end

   // divider and saturation
   always_comb begin
      ntm    = det_ff[3][DW-1] ? unsigned'(-det_ff[3]) : unsigned'(det_ff[3]);
      numm   = {ntm, {FB{1'b0}}};
      den_u  = unsigned'(det_ff[0]);
      trial  = {rem_ff, low_ff[QW-1]};
      diff   = trial - {1'b0, den_u};
      ge     = trial >= {1'b0, den_u};
      lim_hi = {2'b00, {(CW-1){1'b1}}};
      lim_lo = {2'b01, {(CW-1){1'b0}}};
      qneg   = -quot_ff;
      if (ovf_ff) begin
         dist_n = negq_ff ? CMIN : CMAX;
      end else if (negq_ff) begin
         dist_n = (quot_ff > lim_lo) ? CMIN : signed'(qneg[CW-1:0]);
      end else begin
         dist_n = (quot_ff > lim_hi) ? CMAX : signed'(quot_ff[CW-1:0]);
      end
      mag_n  = dist_n[CW-1] ? -{1'b1, unsigned'(dist_n)} : {1'b0, unsigned'(dist_n)};
   end

   // hit vector conversion
   always_comb begin
      cmax_p = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      cmin_p = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};
      adj    = prod_ff[PW-1] ? prod_ff + signed'({{(PW-FB){1'b0}}, {FB{1'b1}}}) : prod_ff;
      shr    = adj >>> FB;
      if (shr > cmax_p) begin
         hv = CMAX;
      end else if (shr < cmin_p) begin
         hv = CMIN;
      end else begin
         hv = shr[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= '0;
            dir_ff[k] <= '0;
            v0_ff[k]  <= '0;
            v1_ff[k]  <= '0;
         end
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         if (cmd.load) begin
            for (int k = 0; k < 3; k++) begin
               case (req_data.req_type)
                  REQ_ORIGIN: org_ff[k] <= coord[k];
                  REQ_DIR:    dir_ff[k] <= coord[k];
                  REQ_V0:     v0_ff[k]  <= coord[k];
                  REQ_V1:     v1_ff[k]  <= coord[k];
                  default:    ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int k = 0; k < 3; k++) begin
            vec_ff[0][k] <= {v1_ff[k][CW-1], v1_ff[k]} - {v0_ff[k][CW-1], v0_ff[k]};
            vec_ff[1][k] <= {coord[k][CW-1], coord[k]} - {v0_ff[k][CW-1], v0_ff[k]};
            vec_ff[2][k] <= {org_ff[k][CW-1], org_ff[k]} - {v0_ff[k][CW-1], v0_ff[k]};
            vec_ff[3][k] <= -{dir_ff[k][CW-1], dir_ff[k]};
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= opa * opb;
      end
      if (ctrl_ff.valid && ctrl_ff.kind != KIND_DIR) begin
         acc_ff <= acc_in;
      end
      if (last_x) begin
         xp_ff[ctrl_ff.idx][ctrl_ff.comp] <= acc_in[XW-1:0];
      end
      if (last_d) begin
         det_ff[ctrl_ff.idx] <= acc_in;
      end
      if (ctrl_ff.valid && ctrl_ff.kind == KIND_DIR) begin
         hit_ff[ctrl_ff.comp] <= hv;
      end
      if (cmd.div_init) begin
         negq_ff <= det_ff[3][DW-1];
         rem_ff  <= {{(DW-(NW-QW)){1'b0}}, numm[NW-1:QW]};
         low_ff  <= numm[QW-1:0];
         quot_ff <= '0;
         ovf_ff  <= {{(DW-(NW-QW)){1'b0}}, numm[NW-1:QW]} >= den_u;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[DW-1:0] : trial[DW-1:0];
         quot_ff <= {quot_ff[QW-2:0], ge};
         low_ff  <= {low_ff[QW-2:0], 1'b0};
      end
      if (cmd.dist_wr) begin
         dist_ff <= dist_n;
         mag_ff  <= mag_n;
      end
      if (cmd.out_load) begin
         rsp_ff.hit      <= cmd.out_hit;
         rsp_ff.distance <= cmd.out_hit ? dist_ff   : '0;
         rsp_ff.hit_x    <= cmd.out_hit ? hit_ff[0] : '0;
         rsp_ff.hit_y    <= cmd.out_hit ? hit_ff[1] : '0;
         rsp_ff.hit_z    <= cmd.out_hit ? hit_ff[2] : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

>>> src/rti_controller.sv
// Controller: accepts beats, sequences cross, dot, divide and hit phases.
// Depends on rti_pkg; commands rti_datapath.
`default_nettype none
module rti_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [2:0]            req_kind,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rti_pkg::rti_cmd_type cmd,
   input  rti_pkg::rti_sts_type sts
);
   import rti_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CROSS  = 4'd1;
   localparam logic [3:0] S_DOT    = 4'd2;
   localparam logic [3:0] S_DRAIN  = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_FIX    = 4'd6;
   localparam logic [3:0] S_HIT    = 4'd7;
   localparam logic [3:0] S_HDRAIN = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [1:0]      idx_ff, idx_in, comp_ff, comp_in;
   logic            half_ff, half_in, hit_ff, hit_in, rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            req_acc;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      comp_in  = comp_ff;
      half_in  = half_ff;
      cnt_in   = cnt_ff;
      hit_in   = hit_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.comp = comp_ff;
      cmd.half = half_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_kind)
                  REQ_ORIGIN, REQ_DIR, REQ_V0, REQ_V1: cmd.load = 1'b1;
                  REQ_TEST: begin
                     cmd.start = 1'b1;
                     state_in  = S_CROSS;
                     idx_in    = '0;
                     comp_in   = '0;
                     half_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_CROSS, S_DOT: begin
            cmd.mul_en = 1'b1;
            cmd.kind   = (state_ff == S_CROSS) ? KIND_CROSS : KIND_DOT;
            half_in    = !half_ff;
            if (half_ff) begin
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  if (state_ff == S_CROSS && idx_ff == 2'd2) begin
                     idx_in   = '0;
                     state_in = S_DOT;
                  end else if (state_ff == S_DOT && idx_ff == 2'd3) begin
                     idx_in   = '0;
                     state_in = S_DRAIN;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         S_DRAIN: state_in = S_CHECK;
         S_CHECK: begin
            if (sts.miss) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(QW - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.dist_wr = 1'b1;
            comp_in     = '0;
            state_in    = S_HIT;
         end
         S_HIT: begin
            cmd.mul_en = 1'b1;
            cmd.kind   = KIND_DIR;
            comp_in    = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = S_HDRAIN;
            end
         end
         S_HDRAIN: begin
            hit_in   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_hit  = hit_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         comp_ff      <= '0;
         half_ff      <= 1'b0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         comp_ff      <= comp_in;
         half_ff      <= half_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_test_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_kind == REQ_TEST) |=> (state_ff == S_CROSS))
      else $error("test beat did not start the sequence");
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a waiting beat");
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= CNTW'(QW - 1)))
      else $error("divide counter out of range");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done state");

endmodule
`default_nettype wire

>>> src/ray_triangle_intersection.sv
// Top level of the ray/triangle intersection block: controller plus datapath.
// Depends on rti_pkg, rti_controller and rti_datapath.
//
//   channel | ports                          | beat
//   --------+--------------------------------+------------------------------
//   request | req_valid req_ready req_data   | one vector, req_type selects
//   result  | rsp_valid rsp_ready rsp_data   | hit, distance, hit vector
//
// A load is stored without leaving the idle state. A hit runs 18 cross-product and 24
// dot-product passes through the shared multiplier, 33 divider steps, 3 hit-vector products,
// plus drain, check, fix and done states; a miss skips divide and hit. Reset is synchronous
// and clears the stored vectors. A waiting result does not block new loads; a further test
// runs, but holds req_ready low in its done state until that result is taken.
`default_nettype none
module ray_triangle_intersection (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  rti_pkg::rti_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rti_pkg::rti_rsp_type rsp_data
);
   import rti_pkg::*;

   rti_cmd_type cmd;
   rti_sts_type sts;

   rti_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rti_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
